// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module ape_check.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define APE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, idle during reset.
`define APE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset is applied.
`define APE_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== rtl/ape_pkg.sv =====
package ape_pkg;

  localparam int DATA_BITS      = 32;
  localparam int LINE_BITS      = 64;
  localparam int PORT_BITS      = 32;
  localparam int LINE_PORT_BITS = 64;
  localparam int CMD_BITS       = 5;
  localparam int SHIFT_BITS     = 5;

  // Load address layout: slice index in the low bits, line choice above it.
  localparam int IDX_MSB     = 3;
  localparam int IDX_BITS    = IDX_MSB + 1;
  localparam int BANK_BIT    = 4;
  localparam int SLICE_COUNT = LINE_BITS / DATA_BITS;

  // One quotient bit per divider stage; plus the input and ALU registers.
  localparam int DIV_STAGES = DATA_BITS;
  localparam int PIPE_DEPTH = DIV_STAGES + 2;
  localparam int CNT_BITS   = $clog2(PIPE_DEPTH + 1);

  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [LINE_BITS-1:0] line_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_NIL    = 5'd0,
    CMD_ADD    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_MUL    = 5'd3,
    CMD_DIV    = 5'd4,
    CMD_SHL    = 5'd5,
    CMD_SHR    = 5'd6,
    CMD_AND    = 5'd7,
    CMD_OR     = 5'd8,
    CMD_XOR    = 5'd9,
    CMD_EQ     = 5'd10,
    CMD_LT     = 5'd11,
    CMD_LE     = 5'd12,
    CMD_SELECT = 5'd13,
    CMD_LOAD   = 5'd14,
    CMD_STORE  = 5'd15,
    CMD_DUMMY  = 5'd16
  } cmd_e;

  // Result fields settled by the ALU stage, carried alongside the divider.
  typedef struct packed {
    data_t value;
    logic  value_ok;
    logic  is_div;
    data_t st_addr;
    data_t st_data;
    logic  st_valid;
    logic  store_cmd;
  } side_t;

  typedef struct packed {
    data_t rem;
    data_t quo;
    data_t den;
    side_t side;
  } div_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // A zero divisor always fits, so the quotient comes out all ones.
  function automatic div_t div_step(div_t cur);
    div_t               nxt;
    logic [DATA_BITS:0] trial;
    logic               qbit;
    nxt   = cur;
    trial = {cur.rem, cur.quo[DATA_BITS-1]};
    qbit  = (trial >= {1'b0, cur.den});
    if (qbit) begin
      trial = trial - {1'b0, cur.den};
    end
    nxt.rem = trial[DATA_BITS-1:0];
    nxt.quo = {cur.quo[DATA_BITS-2:0], qbit};
    return nxt;
  endfunction

endpackage

// ===== rtl/ape_div_pipe.sv =====
module ape_div_pipe
  import ape_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  data_t dividend,
  input  data_t divisor,
  input  side_t in_side,
  output logic  out_valid,
  input  logic  out_ready,
  output data_t quotient,
  output side_t out_side
);

  div_t                  stg [DIV_STAGES];
  div_t                  stg_next [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic                  adv;
  div_t                  init;

  // The whole chain moves together unless the last result is held.
  assign adv      = !vld[DIV_STAGES-1] || out_ready;
  assign in_ready = adv;

  always_comb begin
    init.rem  = '0;
    init.quo  = dividend;
    init.den  = divisor;
    init.side = in_side;
    stg_next[0] = div_step(init);
    for (int i = 1; i < DIV_STAGES; i++) begin
      stg_next[i] = div_step(stg[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = stg[DIV_STAGES-1].quo;
  assign out_side  = stg[DIV_STAGES-1].side;

endmodule

// ===== rtl/array_pe_alu_load_store.sv =====
// Each accepted item passes the input register, the ALU register and then the divider stages.
// Throughput: one item per clock unless the output is held; the divider is a 32-stage pipeline with
// one quotient bit per stage, after an input register and an ALU register.
// Under backpressure the divider chain holds as a whole; the two front registers close bubbles.
// Reset: synchronous, clears all valid bits; the block is ready the next cycle.
module array_pe_alu_load_store
  import ape_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_BITS-1:0]       command,
  input  logic [PORT_BITS-1:0]      operand_a,
  input  logic                      a_valid,
  input  logic [PORT_BITS-1:0]      operand_b,
  input  logic                      b_valid,
  input  logic                      predicate,
  input  logic [LINE_PORT_BITS-1:0] line_one,
  input  logic                      line_one_valid,
  input  logic [LINE_PORT_BITS-1:0] line_two,
  input  logic                      line_two_valid,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PORT_BITS-1:0]      result_value,
  output logic                      result_valid,
  output logic [PORT_BITS-1:0]      store_address,
  output logic [PORT_BITS-1:0]      store_data,
  output logic                      store_valid,
  output logic                      store_cmd
);

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    data_t               a;
    logic                av;
    data_t               b;
    logic                bv;
    logic                pred;
    line_t               l1;
    logic                l1v;
    line_t               l2;
    logic                l2v;
  } op_t;

  op_t   s1;
  logic  s1_v;
  logic  s1_rdy;
  side_t s2_side;
  side_t s2_side_next;
  data_t s2_a;
  data_t s2_b;
  logic  s2_v;
  logic  s2_rdy;
  logic  div_in_ready;
  data_t div_quo;
  side_t fin;

  assign s2_rdy   = !s2_v || div_in_ready;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1.cmd  <= command;
      s1.a    <= operand_a[DATA_BITS-1:0];
      s1.av   <= a_valid;
      s1.b    <= operand_b[DATA_BITS-1:0];
      s1.bv   <= b_valid;
      s1.pred <= predicate;
      s1.l1   <= line_one[LINE_BITS-1:0];
      s1.l1v  <= line_one_valid;
      s1.l2   <= line_two[LINE_BITS-1:0];
      s1.l2v  <= line_two_valid;
    end
  end

  // ALU, load and store decode
  logic                  both;
  logic                  from1;
  logic [IDX_BITS-1:0]   idx;
  logic [SHIFT_BITS-1:0] sh;
  line_t                 sel_line;
  data_t                 ld;

  always_comb begin
    both     = s1.av && s1.bv;
    sh       = s1.b[SHIFT_BITS-1:0];
    idx      = s1.a[IDX_MSB:0];
    from1    = s1.av && !s1.a[BANK_BIT] && s1.l1v;
    sel_line = from1 ? s1.l1 : s1.l2;
    ld       = '0;
    if (int'(idx) < SLICE_COUNT) begin
      ld = data_t'(sel_line >> (int'(idx) * DATA_BITS));
    end

    s2_side_next = '0;
    unique case (s1.cmd)
      CMD_ADD: begin
        s2_side_next.value    = s1.a + s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_SUB: begin
        s2_side_next.value    = s1.a - s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_MUL: begin
        s2_side_next.value    = s1.a * s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_DIV: begin
        s2_side_next.is_div   = 1'b1;
        s2_side_next.value_ok = both;
      end
      CMD_SHL: begin
        s2_side_next.value    = s1.a << sh;
        s2_side_next.value_ok = both;
      end
      CMD_SHR: begin
        s2_side_next.value    = s1.a >> sh;
        s2_side_next.value_ok = both;
      end
      CMD_AND: begin
        s2_side_next.value    = s1.a & s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_OR: begin
        s2_side_next.value    = s1.a | s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_XOR: begin
        s2_side_next.value    = s1.a ^ s1.b;
        s2_side_next.value_ok = both;
      end
      CMD_EQ: begin
        s2_side_next.value    = data_t'(s1.a == s1.b);
        s2_side_next.value_ok = both;
      end
      CMD_LT: begin
        s2_side_next.value    = data_t'(s1.a < s1.b);
        s2_side_next.value_ok = both;
      end
      CMD_LE: begin
        s2_side_next.value    = data_t'(s1.a <= s1.b);
        s2_side_next.value_ok = both;
      end
      CMD_SELECT: begin
        s2_side_next.value    = s1.pred ? s1.b : s1.a;
        s2_side_next.value_ok = both;
      end
      CMD_LOAD: begin
        s2_side_next.value    = ld;
        s2_side_next.value_ok = s1.av && (from1 || s1.l2v);
      end
      CMD_STORE: begin
        s2_side_next.st_addr   = s1.a;
        s2_side_next.st_data   = s1.b;
        s2_side_next.st_valid  = both;
        s2_side_next.store_cmd = 1'b1;
      end
      CMD_DUMMY: begin
        s2_side_next.st_addr  = s1.a;
        s2_side_next.st_valid = 1'b1;
      end
      default: begin
        s2_side_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_rdy) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_side <= s2_side_next;
      s2_a    <= s1.a;
      s2_b    <= s1.b;
    end
  end

  ape_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_v),
    .in_ready  (div_in_ready),
    .dividend  (s2_a),
    .divisor   (s2_b),
    .in_side   (s2_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quotient  (div_quo),
    .out_side  (fin)
  );

  assign result_value  = PORT_BITS'(fin.is_div ? div_quo : fin.value);
  assign result_valid  = fin.value_ok;
  assign store_address = PORT_BITS'(fin.st_addr);
  assign store_data    = PORT_BITS'(fin.st_data);
  assign store_valid   = fin.st_valid;
  assign store_cmd     = fin.store_cmd;

endmodule

// ===== rtl/ape_check.sv =====
`include "assert_macros.svh"

module ape_check
  import ape_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PORT_BITS-1:0] result_value,
  input logic                 result_valid,
  input logic [PORT_BITS-1:0] store_address,
  input logic [PORT_BITS-1:0] store_data,
  input logic                 store_valid,
  input logic                 store_cmd
);

  logic [CNT_BITS-1:0]    cnt;
  logic [CNT_BITS-1:0]    cnt_next;
  logic [3*PORT_BITS-1:0] out_word;

  // Track items inside the block from the port handshakes.
  assign cnt_next = cnt + CNT_BITS'(in_valid && in_ready)
                        - CNT_BITS'(out_valid && out_ready);

  assign out_word = {result_value, store_address, store_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  `APE_ASSERT_RESET(a_reset_empty, !out_valid)
  `APE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `APE_ASSERT_IMP(a_store_no_result, out_valid && store_cmd, !result_valid && result_value == '0)
  `APE_ASSERT_IMP(a_no_request_zero, out_valid && !store_cmd && !store_valid, out_word[2*PORT_BITS-1:0] == '0)
  `APE_ASSERT_IMP(a_occupancy, out_valid, cnt != '0 && cnt <= CNT_BITS'(PIPE_DEPTH))

endmodule

bind array_pe_alu_load_store ape_check u_check (.*);

// ===== bench/array_pe_alu_load_store_tb.sv =====
module array_pe_alu_load_store_tb
  import ape_pkg::*;
();

  localparam int LONG_HOLD      = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = PIPE_DEPTH + 4;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_TOP = 5'd31;

  localparam line_t LINE_A = 64'h0123_4567_89ab_cdef;
  localparam line_t LINE_B = 64'hfedc_ba98_7654_3210;
  localparam data_t ONES   = '1;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    data_t               a;
    logic                av;
    data_t               b;
    logic                bv;
    logic                pred;
    line_t               l1;
    logic                l1v;
    line_t               l2;
    logic                l2v;
  } op_item_t;

  typedef struct packed {
    data_t value;
    logic  value_ok;
    data_t st_addr;
    data_t st_data;
    logic  st_ok;
    logic  st_flag;
  } pe_out_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_BITS-1:0]       command = '0;
  logic [PORT_BITS-1:0]      operand_a = '0;
  logic                      a_valid = 1'b0;
  logic [PORT_BITS-1:0]      operand_b = '0;
  logic                      b_valid = 1'b0;
  logic                      predicate = 1'b0;
  logic [LINE_PORT_BITS-1:0] line_one = '0;
  logic                      line_one_valid = 1'b0;
  logic [LINE_PORT_BITS-1:0] line_two = '0;
  logic                      line_two_valid = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PORT_BITS-1:0]      result_value;
  logic                      result_valid;
  logic [PORT_BITS-1:0]      store_address;
  logic [PORT_BITS-1:0]      store_data;
  logic                      store_valid;
  logic                      store_cmd;

  pe_out_t  pending_q[$];
  op_item_t table_in[$];
  pe_out_t  table_want[$];
  bit       table_known[$];
  bit       cmd_hit[32];

  bit idle_on       = 1'b0;
  bit long_hold_req = 1'b0;
  int errors        = 0;
  int accepted      = 0;
  int checked       = 0;
  int stuck_cycles  = 0;

  array_pe_alu_load_store u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .operand_a     (operand_a),
    .a_valid       (a_valid),
    .operand_b     (operand_b),
    .b_valid       (b_valid),
    .predicate     (predicate),
    .line_one      (line_one),
    .line_one_valid(line_one_valid),
    .line_two      (line_two),
    .line_two_valid(line_two_valid),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .result_valid  (result_valid),
    .store_address (store_address),
    .store_data    (store_data),
    .store_valid   (store_valid),
    .store_cmd     (store_cmd)
  );

  always #2 clk = ~clk;

  function automatic data_t slice_at(line_t line, logic [IDX_MSB:0] idx);
    if (idx >= SLICE_COUNT) begin
      return '0;
    end
    return line[idx*DATA_BITS +: DATA_BITS];
  endfunction

  function automatic pe_out_t pe_result(op_item_t it);
    pe_out_t r;
    logic    both;
    logic    from_one;
    r        = '0;
    both     = it.av && it.bv;
    case (it.cmd)
      CMD_ADD:    begin r.value = it.a + it.b;              r.value_ok = both; end
      CMD_SUB:    begin r.value = it.a - it.b;              r.value_ok = both; end
      CMD_MUL:    begin r.value = it.a * it.b;              r.value_ok = both; end
      CMD_DIV:    begin r.value = (it.b == '0) ? ONES : it.a / it.b; r.value_ok = both; end
      CMD_SHL:    begin r.value = it.a << it.b[SHIFT_BITS-1:0]; r.value_ok = both; end
      CMD_SHR:    begin r.value = it.a >> it.b[SHIFT_BITS-1:0]; r.value_ok = both; end
      CMD_AND:    begin r.value = it.a & it.b;              r.value_ok = both; end
      CMD_OR:     begin r.value = it.a | it.b;              r.value_ok = both; end
      CMD_XOR:    begin r.value = it.a ^ it.b;              r.value_ok = both; end
      CMD_EQ:     begin r.value = data_t'(it.a == it.b);    r.value_ok = both; end
      CMD_LT:     begin r.value = data_t'(it.a < it.b);     r.value_ok = both; end
      CMD_LE:     begin r.value = data_t'(it.a <= it.b);    r.value_ok = both; end
      CMD_SELECT: begin r.value = it.pred ? it.b : it.a;    r.value_ok = both; end
      CMD_LOAD: begin
        // line one only when the address is valid, bank bit is clear and line one is valid
        from_one   = it.av && !it.a[BANK_BIT] && it.l1v;
        r.value    = slice_at(from_one ? it.l1 : it.l2, it.a[IDX_MSB:0]);
        r.value_ok = it.av && (from_one || it.l2v);
      end
      CMD_STORE: begin
        r.st_addr = it.a;
        r.st_data = it.b;
        r.st_ok   = both;
        r.st_flag = 1'b1;
      end
      CMD_DUMMY: begin
        r.st_addr = it.a;
        r.st_ok   = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_item_t mk(logic [CMD_BITS-1:0] cmd, data_t a, logic av, data_t b,
                                  logic bv, logic pred, line_t l1, logic l1v, line_t l2,
                                  logic l2v);
    op_item_t it;
    it.cmd  = cmd;
    it.a    = a;
    it.av   = av;
    it.b    = b;
    it.bv   = bv;
    it.pred = pred;
    it.l1   = l1;
    it.l1v  = l1v;
    it.l2   = l2;
    it.l2v  = l2v;
    return it;
  endfunction

  function automatic pe_out_t rs(data_t value, logic vok, data_t sa, data_t sd, logic sv,
                                 logic st);
    pe_out_t r;
    r.value    = value;
    r.value_ok = vok;
    r.st_addr  = sa;
    r.st_data  = sd;
    r.st_ok    = sv;
    r.st_flag  = st;
    return r;
  endfunction

  task automatic add_row(op_item_t it, bit known, pe_out_t want);
    table_in.push_back(it);
    table_known.push_back(known);
    table_want.push_back(want);
  endtask

  function automatic data_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ONES;
      2:       return data_t'($urandom_range(0, 15));
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic op_item_t rand_item();
    op_item_t it;
    if ($urandom_range(0, 39) == 0) begin
      it.cmd = CMD_BITS'($urandom_range(17, 31));
    end else begin
      it.cmd = CMD_BITS'($urandom_range(0, 16));
    end
    it.a    = rand_word();
    it.b    = rand_word();
    it.av   = ($urandom_range(0, 7) != 0);
    it.bv   = ($urandom_range(0, 7) != 0);
    it.pred = ($urandom_range(0, 1) != 0);
    it.l1   = {$urandom, $urandom};
    it.l2   = {$urandom, $urandom};
    it.l1v  = ($urandom_range(0, 5) != 0);
    it.l2v  = ($urandom_range(0, 5) != 0);
    // keep most loads on the existing slices or the one just past them
    if (it.cmd == CMD_LOAD && $urandom_range(0, 3) != 0) begin
      it.a[IDX_MSB:0] = IDX_BITS'($urandom_range(0, SLICE_COUNT));
    end
    return it;
  endfunction

  task automatic send_item(op_item_t it, bit known, pe_out_t want);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= it.cmd;
    operand_a      <= it.a;
    a_valid        <= it.av;
    operand_b      <= it.b;
    b_valid        <= it.bv;
    predicate      <= it.pred;
    line_one       <= it.l1;
    line_one_valid <= it.l1v;
    line_two       <= it.l2;
    line_two_valid <= it.l2v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(known ? want : pe_result(it));
    cmd_hit[it.cmd] = 1'b1;
    accepted++;
  endtask

  // Drop valid and wait until every result in flight has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [PORT_BITS-1:0] want,
                             logic [PORT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pe_out_t oldest;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual value %h", $time, result_value);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        check_field("result_value", oldest.value, result_value);
        check_field("result_valid", PORT_BITS'(oldest.value_ok), PORT_BITS'(result_valid));
        check_field("store_address", oldest.st_addr, store_address);
        check_field("store_data", oldest.st_data, store_data);
        check_field("store_valid", PORT_BITS'(oldest.st_ok), PORT_BITS'(store_valid));
        check_field("store_cmd", PORT_BITS'(oldest.st_flag), PORT_BITS'(store_cmd));
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("array_pe_alu_load_store_tb: FAIL");
      $finish;
    end
  end

  // Receiver: one long hold on request, short random stalls while idle_on is set.
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 3);
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    pe_out_t none;
    int      hits;
    none = '0;

    add_row(mk(CMD_NIL, '0, 0, '0, 0, 0, '0, 0, '0, 0), 1, none);
    add_row(mk(CMD_NIL, ONES, 1, ONES, 1, 1, '1, 1, '1, 1), 1, none);
    add_row(mk(CMD_ADD, ONES, 1, 32'd1, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 1, '0, '0, 0, 0));
    add_row(mk(CMD_SUB, '0, 1, 32'd1, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(ONES, 1, '0, '0, 0, 0));
    add_row(mk(CMD_MUL, ONES, 1, ONES, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd1, 1, '0, '0, 0, 0));
    add_row(mk(CMD_DIV, 32'd5, 1, '0, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(ONES, 1, '0, '0, 0, 0));
    add_row(mk(CMD_DIV, ONES, 1, 32'd7, 1, 0, LINE_A, 1, LINE_B, 1), 0, none);
    add_row(mk(CMD_SHL, 32'd1, 1, 32'd31, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'h8000_0000, 1, '0, '0, 0, 0));
    add_row(mk(CMD_SHR, ONES, 1, ONES, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd1, 1, '0, '0, 0, 0));
    add_row(mk(CMD_AND, 32'hf0f0_3c3c, 1, 32'hff00_ff00, 1, 0, LINE_A, 1, LINE_B, 1), 0, none);
    add_row(mk(CMD_OR, 32'hf0f0_3c3c, 1, 32'h0f00_00ff, 1, 0, LINE_A, 1, LINE_B, 1), 0, none);
    add_row(mk(CMD_XOR, 32'hf0f0_3c3c, 1, 32'hff00_ff00, 1, 1, LINE_A, 1, LINE_B, 1), 0, none);
    add_row(mk(CMD_EQ, ONES, 1, ONES, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd1, 1, '0, '0, 0, 0));
    add_row(mk(CMD_LT, '0, 1, ONES, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd1, 1, '0, '0, 0, 0));
    add_row(mk(CMD_LE, ONES, 1, '0, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 1, '0, '0, 0, 0));
    add_row(mk(CMD_SELECT, 32'd1, 0, 32'd2, 1, 1, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd2, 0, '0, '0, 0, 0));
    add_row(mk(CMD_SELECT, 32'd1, 1, 32'd2, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd1, 1, '0, '0, 0, 0));
    // load: line one, bank bit to line two, slice past the line, bad address, no lines
    add_row(mk(CMD_LOAD, 32'h1, 1, '0, 0, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'h0123_4567, 1, '0, '0, 0, 0));
    add_row(mk(CMD_LOAD, 32'h10, 1, '0, 0, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'h7654_3210, 1, '0, '0, 0, 0));
    add_row(mk(CMD_LOAD, 32'hf, 1, '0, 0, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 1, '0, '0, 0, 0));
    add_row(mk(CMD_LOAD, 32'h1, 0, '0, 0, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'hfedc_ba98, 0, '0, '0, 0, 0));
    add_row(mk(CMD_LOAD, '0, 1, '0, 0, 0, LINE_A, 0, LINE_B, 0), 1,
            rs(32'h7654_3210, 0, '0, '0, 0, 0));
    add_row(mk(CMD_STORE, ONES, 1, 32'h5a5a_5a5a, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 0, ONES, 32'h5a5a_5a5a, 1, 1));
    add_row(mk(CMD_STORE, 32'h40, 0, 32'h77, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 0, 32'h40, 32'h77, 0, 1));
    add_row(mk(CMD_DUMMY, 32'h1234, 0, ONES, 0, 0, LINE_A, 1, LINE_B, 1), 1,
            rs('0, 0, 32'h1234, '0, 1, 0));
    add_row(mk(CMD_UNUSED_TOP, ONES, 1, ONES, 1, 1, LINE_A, 1, LINE_B, 1), 1, none);
    add_row(mk(CMD_ADD, 32'd3, 0, 32'd4, 1, 0, LINE_A, 1, LINE_B, 1), 1,
            rs(32'd7, 0, '0, '0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (table_in[i]) begin
      send_item(table_in[i], table_known[i], table_want[i]);
    end
    drain();

    // Stall the output long enough to fill the pipe and push back on input.
    idle_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (60) send_item(rand_item(), 0, none);
    idle_on = 1'b1;

    repeat (190) send_item(rand_item(), 0, none);
    drain();
    repeat (190) send_item(rand_item(), 0, none);

    idle_on = 1'b0;
    repeat (40) send_item(rand_item(), 0, none);
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    hits = 0;
    foreach (cmd_hit[c]) hits += cmd_hit[c];
    $display("%0d items sent, %0d results checked, %0d command codes seen", accepted,
             checked, hits);
    $display("random stalls on both sides, one long output hold, drains between phases");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("array_pe_alu_load_store_tb: PASS");
    end else begin
      $display("array_pe_alu_load_store_tb: FAIL");
    end
    $finish;
  end

endmodule
